>>> design/avsc_pkg.sv
`timescale 1ns / 1ps

package avsc_pkg;

    // warm-up length of the drift filter, in accepted updates
    localparam logic [4:0] WARMUP_FRAMES = 5'd20;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // x / 100 == (x * RECIP_DIV100) >> RECIP_SHIFT, exact for x < 2^24
    localparam logic [24:0] RECIP_DIV100 = 25'd21474837;
    localparam int          RECIP_SHIFT  = 31;

    // one in Q0.16, for the (1 - coef) weight
    localparam logic [16:0] WGT_ONE = 17'd65536;

    // rounding half for a shift by 16, and bias for truncation toward zero
    localparam logic signed [63:0] RND_HALF = 64'sd32768;
    localparam logic signed [57:0] ADJ_BIAS = 58'sd65535;

    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    // configuration register indexes
    localparam logic [2:0] CFG_AVG_COEF           = 3'd0;
    localparam logic [2:0] CFG_DIFF_THRESHOLD     = 3'd1;
    localparam logic [2:0] CFG_NOSYNC_THRESHOLD   = 3'd2;
    localparam logic [2:0] CFG_SRC_RATE           = 3'd3;
    localparam logic [2:0] CFG_CORRECTION_PERCENT = 3'd4;

    typedef struct packed {
        logic [15:0] avg_coef;
        logic [30:0] diff_threshold;
        logic [30:0] nosync_threshold;
        logic [18:0] src_rate;
        logic [6:0]  correction_percent;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_LO,
        ST_UPD_HI,
        ST_UPD_SUM,
        ST_UPD_WR,
        ST_AVG_LO,
        ST_AVG_HI,
        ST_AVG_SUM,
        ST_AVG_CMP,
        ST_ADJ,
        ST_LO_DIV,
        ST_LO_WR,
        ST_HI_DIV,
        ST_HI_WR,
        ST_DONE
    } state_t;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MS_ACC_LO_COEF,
        MS_ACC_HI_COEF,
        MS_ACC_LO_WGT,
        MS_ACC_HI_WGT,
        MS_DIFF_RATE,
        MS_N_LOPCT,
        MS_N_HIPCT,
        MS_PROD_RECIP
    } mul_sel_t;

    typedef enum logic [1:0] {
        PS_HOLD,
        PS_LOAD_RND,
        PS_ADD_HI
    } psum_op_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        psum_op_t psum_op;
        logic     acc_wr;
        logic     state_clr;
        logic     warm_inc;
        logic     adj_wr;
        logic     wsum_wr;
        logic     lo_wr;
        logic     res_n;
        logic     res_clamp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic master;
        logic in_range;
        logic warm_done;
        logic corr_big;
    } status_t;

endpackage

>>> design/avsc_dp.sv
`timescale 1ns / 1ps

module avsc_dp
    import avsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic signed [31:0] clock_diff,
    input  logic               diff_valid,
    input  logic               audio_is_master,
    input  logic [15:0]        sample_count,
    output status_t            status,
    output logic [16:0]        res
);

    // filter state
    logic signed [47:0] acc_reg, acc_next;
    logic [4:0]         warm_reg, warm_next;

    // captured word and working registers
    logic signed [31:0] diff_reg, diff_next;
    logic               valid_reg, valid_next;
    logic               master_reg, master_next;
    logic [15:0]        n_reg, n_next;
    logic signed [57:0] prod_reg, prod_next;
    logic signed [63:0] psum_reg, psum_next;
    logic signed [34:0] adj_reg, adj_next;
    logic signed [35:0] wsum_reg, wsum_next;
    logic [16:0]        lo_reg, lo_next;
    logic [16:0]        res_reg, res_next;

    logic [6:0]         pct_eff;
    logic [7:0]         pct_lo;
    logic [7:0]         pct_hi;
    logic [16:0]        wgt;
    logic signed [31:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [57:0] mul_p;
    logic signed [47:0] psum_sh;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic [48:0]        avg_mag;
    logic [32:0]        diff_mag;
    logic signed [57:0] adj_biased;
    logic [16:0]        quot;

    assign pct_eff = (cfg.correction_percent > PCT_FULL) ? PCT_FULL : cfg.correction_percent;
    assign pct_lo  = {1'b0, PCT_FULL - pct_eff};
    assign pct_hi  = {1'b0, PCT_FULL} + {1'b0, pct_eff};
    assign wgt     = WGT_ONE - {1'b0, cfg.avg_coef};

    always_comb
    begin
        case (cmd.mul_sel)
            MS_ACC_LO_COEF:
            begin
                mul_a = {8'd0, acc_reg[23:0]};
                mul_b = {10'd0, cfg.avg_coef};
            end
            MS_ACC_HI_COEF:
            begin
                mul_a = {{8{acc_reg[47]}}, acc_reg[47:24]};
                mul_b = {10'd0, cfg.avg_coef};
            end
            MS_ACC_LO_WGT:
            begin
                mul_a = {8'd0, acc_reg[23:0]};
                mul_b = {9'd0, wgt};
            end
            MS_ACC_HI_WGT:
            begin
                mul_a = {{8{acc_reg[47]}}, acc_reg[47:24]};
                mul_b = {9'd0, wgt};
            end
            MS_DIFF_RATE:
            begin
                mul_a = diff_reg;
                mul_b = {7'd0, cfg.src_rate};
            end
            MS_N_LOPCT:
            begin
                mul_a = {16'd0, n_reg};
                mul_b = {18'd0, pct_lo};
            end
            MS_N_HIPCT:
            begin
                mul_a = {16'd0, n_reg};
                mul_b = {18'd0, pct_hi};
            end
            MS_PROD_RECIP:
            begin
                mul_a = {8'd0, prod_reg[23:0]};
                mul_b = {1'b0, RECIP_DIV100};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 58'(mul_a) * 58'(mul_b);

    // Q.16 result of a rounded product
    assign psum_sh = psum_reg[63:16];

    assign acc_sum = {psum_sh[47], psum_sh} + {{17{diff_reg[31]}}, diff_reg};

    always_comb
    begin
        if (acc_sum[48] != acc_sum[47])
            acc_sat = acc_sum[48] ? ACC_MIN : ACC_MAX;
        else
            acc_sat = acc_sum[47:0];
    end

    assign avg_mag  = psum_sh[47] ? (49'd0 - {psum_sh[47], psum_sh}) : {1'b0, psum_sh};
    assign diff_mag = diff_reg[31] ? (33'd0 - {diff_reg[31], diff_reg}) : {1'b0, diff_reg};

    // diff * rate / 65536 truncated toward zero, and the product / 100 as quot
    assign adj_biased = prod_reg + (prod_reg[57] ? ADJ_BIAS : 58'sd0);
    assign quot       = prod_reg[RECIP_SHIFT +: 17];

    always_comb
    begin
        acc_next    = acc_reg;
        warm_next   = warm_reg;
        diff_next   = diff_reg;
        valid_next  = valid_reg;
        master_next = master_reg;
        n_next      = n_reg;
        prod_next   = prod_reg;
        psum_next   = psum_reg;
        adj_next    = adj_reg;
        wsum_next   = wsum_reg;
        lo_next     = lo_reg;
        res_next    = res_reg;

        if (cmd.load)
        begin
            diff_next   = clock_diff;
            valid_next  = diff_valid;
            master_next = audio_is_master;
            n_next      = sample_count;
        end

        if (cmd.mul_en)
            prod_next = mul_p;

        case (cmd.psum_op)
            PS_LOAD_RND: psum_next = 64'(prod_reg) + RND_HALF;
            PS_ADD_HI:   psum_next = psum_reg + {prod_reg[39:0], 24'd0};
            default:     psum_next = psum_reg;
        endcase

        if (cmd.state_clr)
        begin
            acc_next  = '0;
            warm_next = '0;
        end
        else
        begin
            if (cmd.acc_wr)
                acc_next = acc_sat;
            if (cmd.warm_inc)
                warm_next = warm_reg + 5'd1;
        end

        if (cmd.adj_wr)
            adj_next = adj_biased[50:16];
        if (cmd.wsum_wr)
            wsum_next = {20'd0, n_reg} + {adj_reg[34], adj_reg};
        if (cmd.lo_wr)
            lo_next = quot;

        if (cmd.res_n)
            res_next = {1'b0, n_reg};
        else if (cmd.res_clamp)
        begin
            if (wsum_reg < $signed({19'd0, lo_reg}))
                res_next = lo_reg;
            else if (wsum_reg > $signed({19'd0, quot}))
                res_next = quot;
            else
                res_next = wsum_reg[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            warm_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            warm_reg <= warm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        valid_reg  <= valid_next;
        master_reg <= master_next;
        n_reg      <= n_next;
        prod_reg   <= prod_next;
        psum_reg   <= psum_next;
        adj_reg    <= adj_next;
        wsum_reg   <= wsum_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
    end

    assign status.master    = master_reg;
    assign status.in_range  = valid_reg && (diff_mag < {2'd0, cfg.nosync_threshold});
    assign status.warm_done = (warm_reg >= WARMUP_FRAMES);
    assign status.corr_big  = (avg_mag >= {18'd0, cfg.diff_threshold});
    assign res              = res_reg;

    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg <= WARMUP_FRAMES)
        else $error("warm-up count past its limit");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.state_clr |=> (acc_reg == '0) && (warm_reg == '0))
        else $error("filter not cleared");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_clamp |-> (lo_reg <= quot))
        else $error("clip bounds out of order");

endmodule

>>> design/avsc_ctrl.sv
`timescale 1ns / 1ps

module avsc_ctrl
    import avsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_UPD_LO;
            ST_UPD_LO:
                if (status.master || !status.in_range)
                    state_next = ST_DONE;
                else
                    state_next = ST_UPD_HI;
            ST_UPD_HI:  state_next = ST_UPD_SUM;
            ST_UPD_SUM: state_next = ST_UPD_WR;
            ST_UPD_WR:
                if (status.warm_done)
                    state_next = ST_AVG_LO;
                else
                    state_next = ST_DONE;
            ST_AVG_LO:  state_next = ST_AVG_HI;
            ST_AVG_HI:  state_next = ST_AVG_SUM;
            ST_AVG_SUM: state_next = ST_AVG_CMP;
            ST_AVG_CMP:
                if (status.corr_big)
                    state_next = ST_ADJ;
                else
                    state_next = ST_DONE;
            ST_ADJ:     state_next = ST_LO_DIV;
            ST_LO_DIV:  state_next = ST_LO_WR;
            ST_LO_WR:   state_next = ST_HI_DIV;
            ST_HI_DIV:  state_next = ST_HI_WR;
            ST_HI_WR:   state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MS_ACC_LO_COEF;
        cmd.psum_op = PS_HOLD;
        case (state_reg)
            ST_IDLE:
                cmd.load = in_valid;
            ST_UPD_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ACC_LO_COEF;
                if (status.master)
                    cmd.res_n = 1'b1;
                else if (!status.in_range)
                begin
                    cmd.state_clr = 1'b1;
                    cmd.res_n     = 1'b1;
                end
            end
            ST_UPD_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ACC_HI_COEF;
                cmd.psum_op = PS_LOAD_RND;
            end
            ST_UPD_SUM:
                cmd.psum_op = PS_ADD_HI;
            ST_UPD_WR:
            begin
                cmd.acc_wr = 1'b1;
                if (!status.warm_done)
                begin
                    cmd.warm_inc = 1'b1;
                    cmd.res_n    = 1'b1;
                end
            end
            ST_AVG_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ACC_LO_WGT;
            end
            ST_AVG_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ACC_HI_WGT;
                cmd.psum_op = PS_LOAD_RND;
            end
            ST_AVG_SUM:
                cmd.psum_op = PS_ADD_HI;
            ST_AVG_CMP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DIFF_RATE;
                cmd.res_n   = !status.corr_big;
            end
            ST_ADJ:
            begin
                cmd.adj_wr  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_N_LOPCT;
            end
            ST_LO_DIV:
            begin
                cmd.wsum_wr = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_PROD_RECIP;
            end
            ST_LO_WR:
            begin
                cmd.lo_wr   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_N_HIPCT;
            end
            ST_HI_DIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_PROD_RECIP;
            end
            ST_HI_WR:
                cmd.res_clamp = 1'b1;
            ST_DONE:
                cmd.out_load = out_free;
            default:
                cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_UPD_LO))
        else $error("accepted word did not start the update");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE) && in_valid)
        else $error("input captured outside idle");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a waiting word");

endmodule

>>> design/av_sync_sample_count_corrector.sv
`timescale 1ns / 1ps
// Paths after UPD_LO: straight to DONE (audio master, bad or large difference), via the UPD
// states during warm-up, also the AVG states with no correction, and also ADJ..HI_WR when
// the count is corrected; DONE waits for a free output register. One word at a time; each
// product goes through one shared 32x26 multiplier, one per cycle, and sets the step count.
// Reset (rst_n, async, active low) clears the filter state, the sequencer, the output valid
// and loads the default configuration.

module av_sync_sample_count_corrector
    import avsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // input words, one per decoded audio frame
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] clock_diff,
    input  logic               diff_valid,
    input  logic               audio_is_master,
    input  logic [15:0]        sample_count,

    // result words
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        wanted_count,

    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        out_valid_reg, out_valid_next;
    logic [16:0] wanted_reg, wanted_next;

    cmd_t        cmd;
    status_t     status;
    logic [16:0] res;
    logic        out_free;

    // Configuration is always taken; writes to unused indexes fall through.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AVG_COEF:           cfg_next.avg_coef           = cfg_data[15:0];
                CFG_DIFF_THRESHOLD:     cfg_next.diff_threshold     = cfg_data;
                CFG_NOSYNC_THRESHOLD:   cfg_next.nosync_threshold   = cfg_data;
                CFG_SRC_RATE:           cfg_next.src_rate           = cfg_data[18:0];
                CFG_CORRECTION_PERCENT: cfg_next.correction_percent = cfg_data[6:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_coef           <= 16'd52057;  // about 0.01^(1/20)
            cfg_reg.diff_threshold     <= 31'd3041;   // ~46 ms
            cfg_reg.nosync_threshold   <= 31'd655360; // 10 s
            cfg_reg.src_rate           <= 19'd48000;
            cfg_reg.correction_percent <= 7'd10;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Output register: the sequencer may start the next word while a
    // result still waits here; it only holds in its last step when full and stalled.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        wanted_next    = wanted_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            wanted_next    = res;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        wanted_reg <= wanted_next;
    end

    assign out_valid    = out_valid_reg;
    assign wanted_count = wanted_reg;

    avsc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    avsc_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg_reg),
        .clock_diff      (clock_diff),
        .diff_valid      (diff_valid),
        .audio_is_master (audio_is_master),
        .sample_count    (sample_count),
        .status          (status),
        .res             (res)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import avsc_pkg::*;

    // run guard and drain allowance
    localparam int LIMIT  = 400000;
    localparam int SETTLE = 20;

    // Q32.16 accumulator limits, signed 48 bit
    localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOT = -ACC_TOP - 1;
    localparam longint PCT_TOP = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] clock_diff;
    logic               diff_valid;
    logic               audio_is_master;
    logic [15:0]        sample_count;
    logic               out_valid;
    logic               out_stall;
    logic [16:0]        wanted_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;

    av_sync_sample_count_corrector u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .clock_diff      (clock_diff),
        .diff_valid      (diff_valid),
        .audio_is_master (audio_is_master),
        .sample_count    (sample_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wanted_count    (wanted_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copies (reset values) and filter state
    // ------------------------------------------------------------------
    longint k_coef   = 52057;
    longint k_thr    = 3041;
    longint k_nosync = 655360;
    longint k_rate   = 48000;
    longint k_pct    = 10;

    longint flt_acc  = 0;
    int     flt_warm = 0;

    // expected sample counts, oldest first
    logic [16:0] wanted_q [$];

    int  bad_cnt = 0;
    int  cyc     = 0;
    int  stall_left = 0;
    bit  tx_jitter;
    bit  rx_jitter;
    logic [16:0] exp_w;

    // One frame through the drift filter; returns the sample count to produce.
    function automatic logic [16:0] next_wanted(logic signed [31:0] d_in, logic ok,
                                                logic master, logic [15:0] n_in);
        longint dif, n, mag, p, acc_nx, q, avg, amag, pct, lo, hi, want;
        dif  = d_in;
        n    = n_in;
        want = n;
        if (!master)
        begin
            mag = (dif < 0) ? -dif : dif;
            if (ok && mag < k_nosync)
            begin
                // acc = diff + round(coef * acc), saturated to 48 bit
                p      = flt_acc * k_coef;
                acc_nx = dif + ((p + 32768) >>> 16);
                if (acc_nx > ACC_TOP)
                    acc_nx = ACC_TOP;
                if (acc_nx < ACC_BOT)
                    acc_nx = ACC_BOT;
                flt_acc = acc_nx;
                if (flt_warm < int'(WARMUP_FRAMES))
                    flt_warm++;
                else
                begin
                    // average = round(acc * (1 - coef))
                    q    = flt_acc * (65536 - k_coef);
                    avg  = (q + 32768) >>> 16;
                    amag = (avg < 0) ? -avg : avg;
                    if (amag >= k_thr)
                    begin
                        pct  = (k_pct > PCT_TOP) ? PCT_TOP : k_pct;
                        lo   = n * (PCT_TOP - pct) / PCT_TOP;
                        hi   = n * (PCT_TOP + pct) / PCT_TOP;
                        // signed division truncates toward zero
                        want = n + dif * k_rate / 65536;
                        if (want < lo)
                            want = lo;
                        if (want > hi)
                            want = hi;
                    end
                end
            end
            else
            begin
                // NaN or hopelessly out of sync: filter starts over
                flt_acc  = 0;
                flt_warm = 0;
            end
        end
        return want[16:0];
    endfunction

    // ------------------------------------------------------------------
    // Directed words. want < 0: take the shadow's answer.
    // ------------------------------------------------------------------
    typedef struct {
        logic signed [31:0] diff;
        logic               ok;
        logic               master;
        logic [15:0]        count;
        int                 reps;
        int                 want;
    } dir_row_t;

    dir_row_t dir_tab [0:9] = '{
        // audio is master: count passes through, filter untouched
        '{32'sh8000_0000, 1'b1, 1'b1, 16'hFFFF, 1, 65535},
        // not-a-number difference clears the filter
        '{32'sh7FFF_FFFF, 1'b0, 1'b0, 16'h0000, 1, 0},
        // beyond the no-sync limit, both signs
        '{32'sh7FFF_FFFF, 1'b1, 1'b0, 16'd12345, 1, 12345},
        '{32'sh8000_0000, 1'b1, 1'b0, 16'd1, 1, 1},
        // warm-up: twenty updates, no correction yet
        '{32'sh0000_4000, 1'b1, 1'b0, 16'd1000, 20, 1000},
        // first corrected frames: clipped high, widest count, empty frame
        '{32'sh0000_4000, 1'b1, 1'b0, 16'd1000, 1, -1},
        '{32'sh0000_4000, 1'b1, 1'b0, 16'hFFFF, 1, -1},
        '{32'sh0000_4000, 1'b1, 1'b0, 16'h0000, 1, -1},
        // master in the middle of a warm filter
        '{32'sh0001_0000, 1'b1, 1'b1, 16'd777, 1, 777},
        '{-32'sh0000_0100, 1'b1, 1'b0, 16'd2000, 1, -1}
    };

    // Offer one word; the shadow steps when the block takes it.
    task automatic put_word(input logic signed [31:0] d, input logic ok, input logic mst,
                            input logic [15:0] n, input int typed);
        logic [16:0] w;
        if (tx_jitter && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        clock_diff      <= d;
        diff_valid      <= ok;
        audio_is_master <= mst;
        sample_count    <= n;
        do @(posedge clk); while (in_stall);
        w = next_wanted(d, ok, mst, n);
        if (typed >= 0)
            wanted_q.push_back(typed[16:0]);
        else
            wanted_q.push_back(w);
    endtask

    // Sender holds off until every expected count is back, then lets the
    // sequencer run dry.
    task automatic settle();
        in_valid <= 1'b0;
        while (wanted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_AVG_COEF:           k_coef   = val[15:0];
            CFG_DIFF_THRESHOLD:     k_thr    = val;
            CFG_NOSYNC_THRESHOLD:   k_nosync = val;
            CFG_SRC_RATE:           k_rate   = val[18:0];
            CFG_CORRECTION_PERCENT: k_pct    = val[6:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input longint coef, input longint thr, input longint nosync,
                                 input longint rate, input longint pct);
        write_reg(CFG_AVG_COEF, coef[30:0]);
        write_reg(CFG_DIFF_THRESHOLD, thr[30:0]);
        write_reg(CFG_NOSYNC_THRESHOLD, nosync[30:0]);
        write_reg(CFG_SRC_RATE, rate[30:0]);
        write_reg(CFG_CORRECTION_PERCENT, pct[30:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(256, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly long in-sync runs around a steady drift so the filter gets past
    // warm-up; each run ends with a few broken or foreign words.
    task automatic run_stream(input int quota);
        int     sent;
        int     len;
        longint lim;
        longint drift;
        longint d;
        sent = 0;
        lim  = (k_nosync > 0) ? k_nosync - 1 : 0;
        while (sent < quota)
        begin
            len   = $urandom_range(22, 45);
            if (len > quota - sent)
                len = quota - sent;
            drift = longint'($urandom_range(0, 32'(lim))) >> $urandom_range(0, 20);
            if ($urandom_range(0, 1))
                drift = -drift;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    put_word($urandom, 1'($urandom_range(0, 1)), 1'b1, pick_count(), -1);
                else
                begin
                    d = drift + longint'($urandom_range(0, 512)) - 256;
                    if (d > lim || d < -lim)
                        d = drift;
                    put_word(d[31:0], 1'b1, 1'b0, pick_count(), -1);
                end
                sent++;
            end
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 2))
                    0:       put_word($urandom, 1'b0, 1'b0, pick_count(), -1);
                    1:       put_word($urandom, 1'b1, 1'b0, pick_count(), -1);
                    default: put_word($urandom, 1'($urandom_range(0, 1)), 1'b1,
                                      pick_count(), -1);
                endcase
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, compare against oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (wanted_q.size() == 0)
                begin
                    $display("%0t: unexpected word, wanted_count %0d", $time, wanted_count);
                    bad_cnt++;
                end
                else
                begin
                    exp_w = wanted_q.pop_front();
                    if (wanted_count !== exp_w)
                    begin
                        $display("%0t: wanted_count expected %0d actual %0d",
                                 $time, exp_w, wanted_count);
                        bad_cnt++;
                    end
                end
            end
            // stall bursts, their length drawn at random into stall_left
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (rx_jitter && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 15);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        clock_diff      = '0;
        diff_valid      = 1'b0;
        audio_is_master = 1'b0;
        sample_count    = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_AVG_COEF;
        cfg_data        = '0;
        tx_jitter       = 1'b1;
        rx_jitter       = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset settings
        foreach (dir_tab[r])
            for (int k = 0; k < dir_tab[r].reps; k++)
                put_word(dir_tab[r].diff, dir_tab[r].ok, dir_tab[r].master,
                         dir_tab[r].count, dir_tab[r].want);

        for (int ph = 0; ph < 9; ph++)
        begin
            settle();
            // idling in most phases, none in the last
            tx_jitter = (ph < 8) && ($urandom_range(0, 3) != 0);
            rx_jitter = (ph < 8) && ($urandom_range(0, 3) != 0);
            case (ph)
                // reset values written back explicitly
                0: load_settings(52057, 3041, 655360, 48000, 10);
                // no memory in the filter, always correct, full swing
                1: load_settings(0, 0, 31'h7FFF_FFFF, 384000, 100);
                // heaviest averaging, threshold never met in practice, no swing
                2: load_settings(65535, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 0);
                // zero sample rate and percent above range
                3: load_settings(40000, 100, 1000000, 0, 127);
                // zero no-sync limit: every update clears
                4: load_settings(30000, 50, 0, 44100, 5);
                default:
                    load_settings($urandom_range(0, 65535),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                              : $urandom_range(0, 8000),
                                  $urandom_range(0, 1) ? $urandom_range(65536, 32'h7FFF_FFFF)
                                                       : $urandom_range(1, 2000000),
                                  $urandom_range(1, 384000),
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                              : $urandom_range(0, 100));
            endcase
            run_stream((ph == 4) ? 20 : 70);
        end

        settle();
        if (bad_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
design/avsc_pkg.sv
design/avsc_dp.sv
design/avsc_ctrl.sv
design/av_sync_sample_count_corrector.sv
verif/tb_top.sv
